// File: sv/lbm_pkg.sv
// Shared types, sizes and codes for the learning bridge MAC table.
// No dependencies; lbm_if, lbm_cmp and the core import this package.
`timescale 1ns / 1ps
`default_nettype none

package lbm_pkg;

	localparam int ENTRIES  = 64;
	localparam int PORTS    = 8;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam int MAC_W    = 48;
	localparam int PORT_W   = 3;
	localparam int MASK_W   = 8;
	localparam int ACT_W    = 2;
	localparam int TIME_W   = 32;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Ports that exist, limited to the width of forward_mask
	localparam logic [MASK_W-1:0] PORT_ALL =
		(PORTS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << PORTS) - 1);

	// Aging limit after reset, in ticks
	localparam logic [CFG_W-1:0] AGE_LIMIT_RESET = CFG_W'(230);

	// Operation codes
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_DROP   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FLOOD  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FWD    = 2'd2;
	localparam logic [ACT_W-1:0] ACT_FILTER = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKED_MASK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOD_EXCLUDE = 2'd2;

	typedef struct packed {
		logic [MAC_W-1:0]  addr;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic src_eq;
		logic dst_eq;
		logic aged;
	} cmp_t;

endpackage

`default_nettype wire

// File: sv/lbm_if.sv
// Valid/ready channel interfaces for frame/tick requests and forwarding results.
// Depends on lbm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lbm_req_if;
	import lbm_pkg::*;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [MAC_W-1:0]  dst_mac;
	logic [MAC_W-1:0]  src_mac;
	logic [PORT_W-1:0] in_port;

	modport source (output valid, operation, dst_mac, src_mac, in_port, input ready);
	modport sink (input valid, operation, dst_mac, src_mac, in_port, output ready);
endinterface

interface lbm_rsp_if;
	import lbm_pkg::*;
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] forward_mask;
	logic [ACT_W-1:0]  action;
	logic              learn_failed;

	modport source (output valid, forward_mask, action, learn_failed, input ready);
	modport sink (input valid, forward_mask, action, learn_failed, output ready);
endinterface

`default_nettype wire

// File: sv/learning_bridge_mac_table_core.sv
// Learning bridge MAC address table with aging. A frame request learns or
// refreshes its source address, then looks up its destination and returns one
// result: flood, forward, filter, or drop when it arrives on a blocked or nonexistent port.
// A tick request advances time and ages out stale entries; it returns nothing.
// The table sits in one RAM that is scanned one entry per cycle
// through a shared compare unit. A frame goes through scan, decide and finish
// before its result is ready, a tick through scan only, and a blocked frame
// straight to finish. The block takes no request while a scan runs; a
// finished result waits in an output register while the next request is taken.
// Depends on lbm_pkg, lbm_if, lbm_ram and lbm_cmp.
`timescale 1ns / 1ps
`default_nettype none

module learning_bridge_mac_table_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	lbm_req_if.sink                              req,
	lbm_rsp_if.source                            rsp,
	input  wire logic                            cfg_we,
	input  wire logic [lbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lbm_pkg::CFG_W-1:0]       cfg_wdata
);
	import lbm_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              cmp_vld_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic [ENTRIES-1:0] valid_q;
	logic [TIME_W-1:0] time_q;

	logic [CFG_W-1:0]  age_limit_q;
	logic [MASK_W-1:0] blocked_q;
	logic [MASK_W-1:0] excl_q;

	logic              op_q;
	logic [MAC_W-1:0]  dst_q;
	logic [MAC_W-1:0]  src_q;
	logic [PORT_W-1:0] port_q;

	logic              src_hit_q;
	logic [IDX_W-1:0]  src_idx_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              dst_hit_q;
	logic [PORT_W-1:0] dst_port_q;

	logic [MASK_W-1:0] res_mask_q;
	logic [ACT_W-1:0]  res_act_q;
	logic              res_fail_q;

	logic              out_valid_q;
	logic [MASK_W-1:0] out_mask_q;
	logic [ACT_W-1:0]  out_act_q;
	logic              out_fail_q;

	entry_t            rd_entry;
	entry_t            wr_entry;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	cmp_t              cmp;
	logic              entry_live;
	logic              learned;
	logic              port_ok;
	logic [MASK_W-1:0] flood_mask;
	logic              req_xfer;
	logic              out_load;

	assign req.ready   = (state_q == ST_IDLE);
	assign req_xfer    = req.valid && req.ready;
	assign out_load    = (state_q == ST_FINISH) && (!out_valid_q || rsp.ready);

	assign rsp.valid        = out_valid_q;
	assign rsp.forward_mask = out_mask_q;
	assign rsp.action       = out_act_q;
	assign rsp.learn_failed = out_fail_q;

	assign port_ok    = (int'(req.in_port) < PORTS) && !blocked_q[req.in_port];
	assign learned    = src_hit_q || free_found_q;
	assign entry_live = cmp_vld_s1 && valid_q[cmp_idx_s1];
	assign flood_mask = PORT_ALL & ~excl_q & ~(MASK_W'(1) << port_q);

	assign ram_we         = (state_q == ST_DECIDE) && (op_q == OP_FRAME) && learned;
	assign ram_waddr      = src_hit_q ? src_idx_q : free_idx_q;
	assign wr_entry.addr  = src_q;
	assign wr_entry.port  = port_q;
	assign wr_entry.stamp = time_q;

	lbm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (rd_entry)
	);

	lbm_cmp u_cmp (
		.entry     (rd_entry),
		.src       (src_q),
		.dst       (dst_q),
		.now       (time_q),
		.age_limit (age_limit_q),
		.res       (cmp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= AGE_LIMIT_RESET;
			blocked_q   <= '0;
			excl_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AGE_LIMIT:     age_limit_q <= cfg_wdata;
				REG_BLOCKED_MASK:  blocked_q   <= cfg_wdata[MASK_W-1:0];
				REG_FLOOD_EXCLUDE: excl_q      <= cfg_wdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_q   <= req.operation;
			dst_q  <= req.dst_mac;
			src_q  <= req.src_mac;
			port_q <= req.in_port;
		end
	end

	// sequencer and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			cmp_vld_s1   <= 1'b0;
			cmp_idx_s1   <= '0;
			valid_q      <= '0;
			time_q       <= '0;
			src_hit_q    <= 1'b0;
			src_idx_q    <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			dst_hit_q    <= 1'b0;
			dst_port_q   <= '0;
			res_mask_q   <= '0;
			res_act_q    <= ACT_DROP;
			res_fail_q   <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SCAN) && (int'(cnt_q) < ENTRIES);
			cmp_idx_s1 <= cnt_q[IDX_W-1:0];

			// one entry out of the RAM per cycle
			if (entry_live) begin
				if (op_q == OP_TICK) begin
					if (cmp.aged) begin
						valid_q[cmp_idx_s1] <= 1'b0;
					end
				end else begin
					if (cmp.src_eq && !src_hit_q) begin
						src_hit_q <= 1'b1;
						src_idx_q <= cmp_idx_s1;
					end
					if (cmp.dst_eq && !dst_hit_q) begin
						dst_hit_q  <= 1'b1;
						dst_port_q <= rd_entry.port;
					end
				end
			end else if (cmp_vld_s1 && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= cmp_idx_s1;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						cnt_q        <= '0;
						src_hit_q    <= 1'b0;
						free_found_q <= 1'b0;
						dst_hit_q    <= 1'b0;
						if (req.operation == OP_TICK) begin
							time_q  <= time_q + TIME_W'(1);
							state_q <= ST_SCAN;
						end else if (port_ok) begin
							state_q <= ST_SCAN;
						end else begin
							res_mask_q <= '0;
							res_act_q  <= ACT_DROP;
							res_fail_q <= 1'b0;
							state_q    <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					if (int'(cnt_q) < ENTRIES) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						// last entry is compared in this cycle
						state_q <= (op_q == OP_TICK) ? ST_IDLE : ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					res_fail_q <= !learned;
					if (learned && !src_hit_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
					if (dst_q == src_q) begin
						// source learned first, so the lookup lands on the arrival port
						res_act_q  <= learned ? ACT_FILTER : ACT_FLOOD;
						res_mask_q <= learned ? '0 : flood_mask;
					end else if (!dst_hit_q) begin
						res_act_q  <= ACT_FLOOD;
						res_mask_q <= flood_mask;
					end else if (dst_port_q == port_q) begin
						res_act_q  <= ACT_FILTER;
						res_mask_q <= '0;
					end else begin
						res_act_q  <= ACT_FWD;
						res_mask_q <= MASK_W'(1) << dst_port_q;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_mask_q <= res_mask_q;
			out_act_q  <= res_act_q;
			out_fail_q <= res_fail_q;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> int'(cnt_q) <= ENTRIES)
		else $error("scan counter past table end");

	a_fail_not_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.learn_failed |-> rsp.action != ACT_DROP)
		else $error("learn failure reported on a dropped frame");

	a_filter_mask: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.action == ACT_FILTER || rsp.action == ACT_DROP)
			|-> rsp.forward_mask == '0)
		else $error("filtered or dropped frame has ports set");

	a_fwd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.action == ACT_FWD |-> $onehot(rsp.forward_mask))
		else $error("forwarded frame not sent to exactly one port");

	a_busy_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while a previous one is in progress");

endmodule

`default_nettype wire

// File: sv/lbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module lbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: sv/lbm_cmp.sv
// Shared compare unit: matches one table entry against source and destination
// and checks its age. Depends on lbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbm_cmp (
	input  wire lbm_pkg::entry_t                  entry,
	input  wire logic [lbm_pkg::MAC_W-1:0]        src,
	input  wire logic [lbm_pkg::MAC_W-1:0]        dst,
	input  wire logic [lbm_pkg::TIME_W-1:0]       now,
	input  wire logic [lbm_pkg::CFG_W-1:0]        age_limit,
	output lbm_pkg::cmp_t                         res
);
	import lbm_pkg::*;

	logic [TIME_W-1:0] age;

	always_comb begin
		age        = now - entry.stamp;  // wraps modulo 2^32
		res.src_eq = (entry.addr == src);
		res.dst_eq = (entry.addr == dst);
		res.aged   = (age > TIME_W'(age_limit));
	end

endmodule

`default_nettype wire
